### src/aar_pkg.sv
// ----------------------------------------------------------------------------
// aar_pkg
// Types, fixed-point constants and the sine table of the axis-angle converter.
// ----------------------------------------------------------------------------
package aar_pkg;

  localparam int ANGLE_BITS  = 12;
  localparam int FRAC_BITS   = 14;
  localparam int DATA_BITS   = 16;
  localparam int CIRCLE_BITS = ANGLE_BITS + 1;
  localparam int QUARTER     = 1 << (ANGLE_BITS - 1);
  localparam int CIRCLE      = 1 << CIRCLE_BITS;
  localparam int TRIG_BITS   = FRAC_BITS + 2;       // signed, holds +-one
  localparam int PROD_BITS   = 2 * DATA_BITS;       // 16 x 16 product
  localparam int RND1_BITS   = PROD_BITS - FRAC_BITS;
  localparam int M_BITS      = FRAC_BITS + 3;       // one minus cosine, 0..2*one
  localparam int PROD2_BITS  = RND1_BITS + M_BITS;
  localparam int RND2_BITS   = PROD2_BITS - FRAC_BITS;
  localparam int SUM_BITS    = RND2_BITS + 1;
  localparam real PI_REAL    = 3.14159265358979323846;

  localparam logic [0:0] OP_QUAT   = 1'b0;
  localparam logic [0:0] OP_MATRIX = 1'b1;

  typedef struct packed {
    logic [0:0]                   op;
    logic signed [DATA_BITS-1:0]  axis_x;
    logic signed [DATA_BITS-1:0]  axis_y;
    logic signed [DATA_BITS-1:0]  axis_z;
    logic [ANGLE_BITS-1:0]        turn;
  } req_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] e0;
    logic signed [DATA_BITS-1:0] e1;
    logic signed [DATA_BITS-1:0] e2;
    logic signed [DATA_BITS-1:0] e3;
    logic signed [DATA_BITS-1:0] e4;
    logic signed [DATA_BITS-1:0] e5;
    logic signed [DATA_BITS-1:0] e6;
    logic signed [DATA_BITS-1:0] e7;
    logic signed [DATA_BITS-1:0] e8;
  } res_t;

  typedef logic [FRAC_BITS:0] sine_rom_t [0:QUARTER];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    real a;
    for (int k = 0; k <= QUARTER; k++) begin
      a = (2.0 ** FRAC_BITS) * $sin(2.0 * PI_REAL * k / CIRCLE);
      t[k] = (FRAC_BITS + 1)'($rtoi($floor(a + 0.5)));
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Fold the circle onto the quarter wave.
  function automatic logic signed [TRIG_BITS-1:0] circle_sin(
    input logic [CIRCLE_BITS-1:0] idx
  );
    logic [1:0]            quad;
    logic [ANGLE_BITS-2:0] r;
    logic [ANGLE_BITS-1:0] addr;
    logic signed [TRIG_BITS-1:0] v;
    quad = idx[CIRCLE_BITS-1 -: 2];
    r    = idx[ANGLE_BITS-2:0];
    addr = quad[0] ? ANGLE_BITS'(QUARTER) - {1'b0, r} : {1'b0, r};
    v    = $signed({1'b0, SINE_ROM[addr]});
    return quad[1] ? -v : v;
  endfunction

  function automatic logic signed [DATA_BITS-1:0] sat16(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [SUM_BITS-1:0] hi;
    logic signed [SUM_BITS-1:0] lo;
    hi = SUM_BITS'(32767);
    lo = -SUM_BITS'(32768);
    if (v > hi) return DATA_BITS'(hi);
    if (v < lo) return DATA_BITS'(lo);
    return v[DATA_BITS-1:0];
  endfunction

endpackage

### src/axis_angle_to_rotation.sv
// Throughput: one item per cycle unless the output stalls; four register stages
// (table lookup, axis products, products with one minus cosine, sums and
// saturation). A stalled result holds the whole pipeline.
// Reset (rst, synchronous) clears all stage valid bits.
// ----------------------------------------------------------------------------
// axis_angle_to_rotation
// Axis and binary angle to unit quaternion or Rodrigues rotation matrix.
// ----------------------------------------------------------------------------
module axis_angle_to_rotation (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  aar_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output aar_pkg::res_t res
);
  import aar_pkg::*;

  function automatic logic signed [RND1_BITS-1:0] rnd1(
    input logic signed [DATA_BITS-1:0] a,
    input logic signed [DATA_BITS-1:0] b
  );
    logic signed [PROD_BITS-1:0] p;
    p = a * b;
    p = p + PROD_BITS'(1 << (FRAC_BITS - 1));
    return p[PROD_BITS-1:FRAC_BITS];
  endfunction

  function automatic logic signed [RND2_BITS-1:0] rnd2(
    input logic signed [RND1_BITS-1:0] a,
    input logic signed [M_BITS-1:0]    b
  );
    logic signed [PROD2_BITS-1:0] p;
    p = a * b;
    p = p + PROD2_BITS'(1 << (FRAC_BITS - 1));
    return p[PROD2_BITS-1:FRAC_BITS];
  endfunction

  logic advance;
  assign advance   = !(res_valid && res_stall);
  assign req_stall = !advance;

  // stage 1
  logic v1;
  logic [0:0] op1;
  logic signed [DATA_BITS-1:0] x1, y1, z1;
  logic signed [TRIG_BITS-1:0] sn1, cs1;
  logic [CIRCLE_BITS-1:0] idx;
  assign idx = (req.op == OP_MATRIX) ? {req.turn, 1'b0} : {1'b0, req.turn};

  // stage 2
  logic v2;
  logic [0:0] op2;
  logic signed [RND1_BITS-1:0] xx2, yy2, zz2, xy2, xz2, yz2, sx2, sy2, sz2;
  logic signed [M_BITS-1:0] m2;
  logic signed [TRIG_BITS-1:0] c2;

  // stage 3
  logic v3;
  logic [0:0] op3;
  logic signed [RND2_BITS-1:0] xxm3, yym3, zzm3, xym3, xzm3, yzm3;
  logic signed [RND1_BITS-1:0] sx3, sy3, sz3;
  logic signed [TRIG_BITS-1:0] c3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op1 <= req.op;
      x1  <= req.axis_x;
      y1  <= req.axis_y;
      z1  <= req.axis_z;
      sn1 <= circle_sin(idx);
      cs1 <= circle_sin(idx + CIRCLE_BITS'(QUARTER));

      op2 <= op1;
      xx2 <= rnd1(x1, x1);
      yy2 <= rnd1(y1, y1);
      zz2 <= rnd1(z1, z1);
      xy2 <= rnd1(x1, y1);
      xz2 <= rnd1(x1, z1);
      yz2 <= rnd1(y1, z1);
      sx2 <= rnd1(x1, DATA_BITS'(sn1));
      sy2 <= rnd1(y1, DATA_BITS'(sn1));
      sz2 <= rnd1(z1, DATA_BITS'(sn1));
      m2  <= M_BITS'(1 << FRAC_BITS) - M_BITS'(cs1);
      c2  <= cs1;

      op3  <= op2;
      xxm3 <= rnd2(xx2, m2);
      yym3 <= rnd2(yy2, m2);
      zzm3 <= rnd2(zz2, m2);
      xym3 <= rnd2(xy2, m2);
      xzm3 <= rnd2(xz2, m2);
      yzm3 <= rnd2(yz2, m2);
      sx3  <= sx2;
      sy3  <= sy2;
      sz3  <= sz2;
      c3   <= c2;

      if (op3 == OP_MATRIX) begin
        res.e0 <= sat16(SUM_BITS'(xxm3) + SUM_BITS'(c3));
        res.e1 <= sat16(SUM_BITS'(xym3) - SUM_BITS'(sz3));
        res.e2 <= sat16(SUM_BITS'(xzm3) + SUM_BITS'(sy3));
        res.e3 <= sat16(SUM_BITS'(xym3) + SUM_BITS'(sz3));
        res.e4 <= sat16(SUM_BITS'(yym3) + SUM_BITS'(c3));
        res.e5 <= sat16(SUM_BITS'(yzm3) - SUM_BITS'(sx3));
        res.e6 <= sat16(SUM_BITS'(xzm3) - SUM_BITS'(sy3));
        res.e7 <= sat16(SUM_BITS'(yzm3) + SUM_BITS'(sx3));
        res.e8 <= sat16(SUM_BITS'(zzm3) + SUM_BITS'(c3));
      end else begin
        res.e0 <= sat16(SUM_BITS'(c3));
        res.e1 <= sat16(SUM_BITS'(sx3));
        res.e2 <= sat16(SUM_BITS'(sy3));
        res.e3 <= sat16(SUM_BITS'(sz3));
        res.e4 <= '0;
        res.e5 <= '0;
        res.e6 <= '0;
        res.e7 <= '0;
        res.e8 <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  // an item that meets no stall passes every stage register and reaches the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) ##1 !req_stall ##1 !req_stall ##1 !req_stall |=> res_valid)
    else $error("accepted item did not reach the output in time");

  // hold every stage while the output is stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    req_stall |=> $stable(v1) && $stable(v2) && $stable(v3))
    else $error("pipeline moved during a stall");
`endif

endmodule

### sim/tb_axis_angle_to_rotation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_axis_angle_to_rotation
// Self-checking bench for the axis-angle converter. Poses are driven from a
// queue. Each accepted pose is converted in the bench's own fixed-point math,
// and the rotation it gives is compared field by field with the block's
// output. Random idling runs on both sides, with one long output hold.
// ----------------------------------------------------------------------------
module tb_axis_angle_to_rotation;
  import aar_pkg::*;

  localparam int N_RANDOM  = 1300;
  localparam int HOLD_LONG = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  axis_angle_to_rotation DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  req_t    pending_poses[$];
  res_t    due_rotations[$];
  longint  quarter_sine[0:QUARTER];
  bit      loading_done = 1'b0;
  int      taken_seen = 0;
  bit      quiet = 1'b0;
  int      mismatches = 0;
  int      poses_accepted = 0;
  int      send_gap = 0;
  int      recv_gap = 0;
  int      long_hold = 0;
  bit      long_hold_done = 1'b0;

  function automatic longint trig_sin(int unsigned idx);
    int unsigned i, q, r;
    longint v;
    i = idx % CIRCLE;
    q = i / QUARTER;
    r = i % QUARTER;
    v = (q & 1) ? quarter_sine[QUARTER - r] : quarter_sine[r];
    return (q & 2) ? -v : v;
  endfunction

  // Round to nearest, ties up; >>> floors for negative values.
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b + (longint'(1) << (FRAC_BITS - 1));
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic res_t predict_rotation(req_t p);
    res_t r;
    longint x, y, z, c, s, m, sh, xym, xzm, yzm, sx, sy, sz;
    int unsigned t;
    x = p.axis_x;
    y = p.axis_y;
    z = p.axis_z;
    t = p.turn;
    r = '0;
    if (p.op == OP_QUAT) begin
      sh = trig_sin(t);
      r.e0 = clip16(trig_sin(t + QUARTER));
      r.e1 = clip16(fx_mul(sh, x));
      r.e2 = clip16(fx_mul(sh, y));
      r.e3 = clip16(fx_mul(sh, z));
    end else begin
      c = trig_sin(2 * t + QUARTER);
      s = trig_sin(2 * t);
      m = (longint'(1) << FRAC_BITS) - c;
      xym = fx_mul(fx_mul(x, y), m);
      xzm = fx_mul(fx_mul(x, z), m);
      yzm = fx_mul(fx_mul(y, z), m);
      sx = fx_mul(x, s);
      sy = fx_mul(y, s);
      sz = fx_mul(z, s);
      r.e0 = clip16(fx_mul(fx_mul(x, x), m) + c);
      r.e1 = clip16(xym - sz);
      r.e2 = clip16(xzm + sy);
      r.e3 = clip16(xym + sz);
      r.e4 = clip16(fx_mul(fx_mul(y, y), m) + c);
      r.e5 = clip16(yzm - sx);
      r.e6 = clip16(xzm - sy);
      r.e7 = clip16(yzm + sx);
      r.e8 = clip16(fx_mul(fx_mul(z, z), m) + c);
    end
    return r;
  endfunction

  function automatic req_t make_pose(logic [0:0] op, int ax, int ay, int az, int t);
    req_t p;
    p.op = op;
    p.axis_x = ax[15:0];
    p.axis_y = ay[15:0];
    p.axis_z = az[15:0];
    p.turn = t[ANGLE_BITS-1:0];
    return p;
  endfunction

  function automatic int rand_axis();
    // Mostly within plus or minus one, sometimes the full range.
    if ($urandom_range(0, 3) == 0) return $signed(16'($urandom));
    return $urandom_range(0, 32768) - 16384;
  endfunction

  initial begin
    int turns[8];
    real a;
    turns = '{0, 1, 1023, 1024, 2048, 3072, 4095, 683};
    for (int k = 0; k <= QUARTER; k++) begin
      a = 16384.0 * $sin(2.0 * 3.14159265358979323846 * k / CIRCLE);
      quarter_sine[k] = longint'($floor(a + 0.5));
    end
    // Extremes, unit axes, zero axis, every quadrant of the angle.
    for (int i = 0; i < 8; i++) begin
      pending_poses.push_back(make_pose(OP_QUAT, 16384, 0, 0, turns[i]));
      pending_poses.push_back(make_pose(OP_MATRIX, 0, 16384, 0, turns[i]));
    end
    pending_poses.push_back(make_pose(OP_MATRIX, 0, 0, 16384, 512));
    pending_poses.push_back(make_pose(OP_MATRIX, 32767, 32767, 32767, 1024));
    pending_poses.push_back(make_pose(OP_MATRIX, -32768, -32768, -32768, 3000));
    pending_poses.push_back(make_pose(OP_QUAT, -32768, 32767, -32768, 2048));
    pending_poses.push_back(make_pose(OP_MATRIX, 0, 0, 0, 1500));
    pending_poses.push_back(make_pose(OP_QUAT, 9459, 9459, 9459, 4095));
    pending_poses.push_back(make_pose(OP_MATRIX, 32767, -32768, 0, 700));
    for (int i = 0; i < N_RANDOM; i++)
      pending_poses.push_back(make_pose(1'($urandom_range(0, 1)), rand_axis(), rand_axis(),
                                        rand_axis(), $urandom_range(0, 4095)));
    loading_done = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (pending_poses.size() == 0 && due_rotations.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && due_rotations.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end

  // Accept poses and check rotations at the rising edge.
  always @(posedge clk) begin
    res_t want;
    if (!rst && req_valid && !req_stall) begin
      due_rotations.push_back(predict_rotation(req));
      void'(pending_poses.pop_front());
      poses_accepted++;
    end
    if (!rst && res_valid && !res_stall) begin
      if (due_rotations.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected rotation %h", res);
      end else begin
        want = due_rotations.pop_front();
        for (int f = 0; f < 9; f++)
          if (res[143 - 16*f -: 16] !== want[143 - 16*f -: 16]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("e%0d mismatch: expected %0d got %0d", f,
                       $signed(want[143 - 16*f -: 16]), $signed(res[143 - 16*f -: 16]));
          end
      end
    end
  end

  // Pose driver: hold valid until taken, idle in bursts.
  always @(negedge clk) begin
    bit offer;
    offer = req_valid;
    if (taken_seen != poses_accepted) begin
      taken_seen <= poses_accepted;
      offer = 1'b0;
    end
    if (loading_done && pending_poses.size() < 120) quiet <= 1'b1;
    if (!offer && !rst) begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(0, 12);
      else if (pending_poses.size() > 0) begin
        req <= pending_poses[0];
        offer = 1'b1;
      end
    end
    req_valid <= offer;
  end

  // Rotation receiver: random stall bursts plus one long hold.
  always @(negedge clk) begin
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      res_stall <= 1'b1;
    end else if (!long_hold_done && poses_accepted >= 400) begin
      long_hold_done <= 1'b1;
      long_hold <= HOLD_LONG;
      res_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      res_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(0, 12);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

endmodule

### filelist.f
src/aar_pkg.sv
src/axis_angle_to_rotation.sv
sim/tb_axis_angle_to_rotation.sv
